### rtl/assert_macros.svh
// Assertion macros for the RTL files; serial_command_frame_builder includes them.
// Depends on clk and rst_n being visible at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/scfb_pkg.sv
// Package for the serial command frame builder: widths, constants, beat types.
// No dependencies.
package scfb_pkg;

  localparam int MAX_DATA_DEF = 16;
  localparam int ADDR_W       = 5;
  localparam int COUNT_W      = 5;
  localparam int BYTE_W       = 8;

  localparam logic [COUNT_W-1:0] LONG_FORM_LIMIT = 5'd6;
  localparam logic [2:0]         LONG_FORM_CODE  = 3'd7;
  localparam logic [ADDR_W-1:0]  ADDR_RESET      = 5'd1;

  typedef struct packed {
    logic [BYTE_W-1:0]  command_code;
    logic [COUNT_W-1:0] data_count;
    logic [31:0]        data_value;
  } scfb_in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] frame_byte;
    logic              last_byte;
  } scfb_out_t;

  typedef struct packed {
    logic      valid;
    scfb_out_t beat;
  } scfb_cell_t;

endpackage

### rtl/scfb_cell.sv
// One stage of the frame shift chain: holds one frame byte and its flags.
// Depends on scfb_pkg.
module scfb_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  logic                shift,
  input  scfb_pkg::scfb_cell_t load_data,
  input  scfb_pkg::scfb_cell_t next_data,
  output scfb_pkg::scfb_cell_t cell_data
);
  import scfb_pkg::*;

  logic      valid_r, valid_nxt;
  scfb_out_t beat_r, beat_nxt;

  always_comb begin
    valid_nxt = valid_r;
    beat_nxt  = beat_r;
    if (load) begin
      valid_nxt = load_data.valid;
      beat_nxt  = load_data.beat;
    end else if (shift) begin
      valid_nxt = next_data.valid;
      beat_nxt  = next_data.beat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    beat_r <= beat_nxt;
  end

  assign cell_data.valid = valid_r;
  assign cell_data.beat  = beat_r;

endmodule

### rtl/scfb_frame_gen.sv
// Lays out a whole command frame, one entry per chain cell, with checksum.
// Depends on scfb_pkg.
module scfb_frame_gen #(
  parameter int MAX_DATA = scfb_pkg::MAX_DATA_DEF
) (
  input  scfb_pkg::scfb_in_t                 cmd,
  input  logic [scfb_pkg::ADDR_W-1:0]        dev_addr,
  output scfb_pkg::scfb_cell_t [MAX_DATA+3:0] frame
);
  import scfb_pkg::*;

  localparam int NCELL = MAX_DATA + 4;

  logic [COUNT_W-1:0]  cnt;
  logic                long_form;
  logic [BYTE_W-1:0]   hdr;
  logic [BYTE_W-1:0]   csum;
  logic [3:0][BYTE_W-1:0] vb;
  int                  dstart;

  always_comb begin
    if (int'(cmd.data_count) > MAX_DATA) begin
      cnt = COUNT_W'(MAX_DATA);
    end else begin
      cnt = cmd.data_count;
    end
    long_form = (cnt > LONG_FORM_LIMIT);
    // short form: low header bits are the count itself (count <= 6)
    hdr    = {dev_addr, long_form ? LONG_FORM_CODE : cnt[2:0]};
    dstart = long_form ? 3 : 2;
    vb     = cmd.data_value;
    csum   = hdr ^ cmd.command_code ^ (long_form ? BYTE_W'(cnt) : '0);
    for (int j = 0; j < 4; j++) begin
      if (j < int'(cnt)) begin
        csum = csum ^ vb[j];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NCELL; k++) begin
      int di;
      di = k - dstart;
      frame[k].valid          = (k <= dstart + int'(cnt));
      frame[k].beat.last_byte = 1'b0;
      frame[k].beat.frame_byte = '0;
      if (k == 0) begin
        frame[k].beat.frame_byte = hdr;
      end else if (k == 1) begin
        frame[k].beat.frame_byte = cmd.command_code;
      end else if (long_form && k == 2) begin
        frame[k].beat.frame_byte = BYTE_W'(cnt);
      end else if (di < int'(cnt)) begin
        // data bytes past the fourth stay zero
        if (di < 4) begin
          frame[k].beat.frame_byte = vb[di[1:0]];
        end
      end else if (di == int'(cnt)) begin
        frame[k].beat.frame_byte = csum;
        frame[k].beat.last_byte  = 1'b1;
      end
    end
  end

endmodule

### rtl/serial_command_frame_builder.sv
// The first frame byte is offered in the cycle after the command beat is taken.
// Throughput: one frame byte per cycle while out_ready is high, out of a shift
// chain of MAX_DATA+4 cells; a frame is count+3 bytes (count+4 when count > 6, so
// 20 at count 16); the next command loads in the cycle the checksum byte leaves.
// Reset (rst_n, synchronous, active low) empties the chain and sets address to 1.
// Top level; depends on scfb_pkg, scfb_frame_gen, scfb_cell, assert_macros.svh.
`include "assert_macros.svh"
module serial_command_frame_builder #(
  parameter int MAX_DATA = scfb_pkg::MAX_DATA_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  scfb_pkg::scfb_in_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output scfb_pkg::scfb_out_t           out_data,
  input  logic                          cfg_we,
  input  logic [scfb_pkg::ADDR_W-1:0]   cfg_data
);
  import scfb_pkg::*;

  localparam int NCELL = MAX_DATA + 4;

  logic [ADDR_W-1:0] dev_addr_r, dev_addr_nxt;
  scfb_cell_t [NCELL-1:0] frame;
  scfb_cell_t [NCELL-1:0] chain;
  logic load, shift, in_fire, out_fire;

  always_comb begin
    dev_addr_nxt = cfg_we ? cfg_data : dev_addr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= ADDR_RESET;
    end else begin
      dev_addr_r <= dev_addr_nxt;
    end
  end

  scfb_frame_gen #(.MAX_DATA(MAX_DATA)) u_gen (
    .cmd      (in_data),
    .dev_addr (dev_addr_r),
    .frame    (frame)
  );

  // chain is packed toward cell 0; when cell 0 holds the checksum the rest is empty
  assign out_valid = chain[0].valid;
  assign out_data  = chain[0].beat;
  assign in_ready  = !chain[0].valid || (chain[0].beat.last_byte && out_ready);
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;
  assign load      = in_fire;
  assign shift     = out_fire;

  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    scfb_cell_t next_c;
    if (g == NCELL - 1) begin : g_tail
      assign next_c = '0;
    end else begin : g_mid
      assign next_c = chain[g+1];
    end
    scfb_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .load      (load),
      .shift     (shift),
      .load_data (frame[g]),
      .next_data (next_c),
      .cell_data (chain[g])
    );
  end

  `ASSERT_NEXT(a_load_shows, in_fire, out_valid && !out_data.last_byte, "frame not presented after load")
  `ASSERT_NEXT(a_mid_frame, out_fire && !out_data.last_byte, out_valid, "frame broken before checksum")
  `ASSERT_NEXT(a_frame_end, out_fire && out_data.last_byte && !in_fire, !out_valid, "bytes after checksum")
  `ASSERT_IMPL(a_tail_idle, chain[0].valid && chain[0].beat.last_byte, !chain[1].valid, "stale byte behind checksum")

endmodule
